// File: rtl/clp_pkg.sv
package clp_pkg;

  // Number of Legendre terms held per range (coeff_index is 4 bits wide)
  localparam int MAX_TERMS = 16;
  localparam int TERM_W    = $clog2(MAX_TERMS);
  localparam int NCNT_W    = TERM_W + 1;

  // Q1.30 unity and register reset values
  localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
  localparam logic [15:0]        SPO_RESET = 16'd100;
  localparam logic [4:0]         MT_RESET  = 5'd10;

  // Configuration register indexes
  typedef enum logic {
    REG_SAMPLES_PER_ORDER = 1'b0,
    REG_MAX_TERMS         = 1'b1
  } cfg_reg_t;

  // Divider quotient lengths
  typedef enum logic [1:0] {
    DIV_Q16,
    DIV_Q36,
    DIV_Q48
  } div_mode_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PICK_ST,
    S_PICK_WT,
    S_X_ST,
    S_X_WT,
    S_MS,
    S_ACC,
    S_R1,
    S_R2,
    S_R3,
    S_R4,
    S_R5,
    S_E_RD,
    S_E_WR
  } state_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic [15:0]        range_length;
    logic               range_last;
  } sample_t;

  typedef struct packed {
    logic signed [47:0] coeff_value;
    logic [3:0]         coeff_index;
    logic               coeff_last;
  } coeff_t;

endpackage

// File: rtl/cut_legendre_projection_core.sv
// Cut-range Legendre projection.
// Samples of a cut range enter on the sample channel (sample_valid / sample_stall),
// one beat per sample, tagged with the range length and a last-sample flag.
// On the last sample the block sends one beat per term on the coeff channel
// (coeff_valid / coeff_stall): orders 0..n-1, coeff_last on the final one.
// The block takes one sample at a time; sample_stall is high while it works.
// Per sample: at range start the term count is picked through the divider,
// then the position is mapped to x through the divider (skipped when the position
// is at or past the end); terms 0 and 1 need no division, and each further
// term takes a division by the order in the shared divider.
// The run of n coefficients then leaves through S_E_RD and S_E_WR for each
// beat; the sample channel stays stalled until the run is out.
// A stalled coeff beat holds in the output register; the run waits on it.
// Synchronous reset: registers to 100 and 10, position to range start,
// channels empty. Configuration writes (cfg_we) take effect at once.
module cut_legendre_projection_core
  import clp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  output logic        coeff_valid,
  input  logic        coeff_stall,
  output coeff_t      coeff,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  state_t state, state_next;

  // Configuration
  logic [15:0] spo;
  logic [4:0]  mtl;

  // Item and range state
  logic signed [31:0] smp;
  logic [15:0]        len_q;
  logic               last_q;
  logic [15:0]        pos;
  logic [NCNT_W-1:0]  n_terms;
  logic [TERM_W-1:0]  p;
  logic [TERM_W-1:0]  idx;
  logic signed [31:0] x;
  logic signed [31:0] pcur;
  logic signed [31:0] pprev;
  logic signed [36:0] num;
  logic               neg;

  // Coefficient sums
  logic signed [47:0] sums [MAX_TERMS];
  logic signed [47:0] rdata;
  logic [TERM_W-1:0]  rd_addr;

  // Shared units
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               div_start, div_busy, div_done;
  div_mode_t          div_mode;
  logic [47:0]        div_dividend, quotient;
  logic [15:0]        div_divisor;

  clp_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  clp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .mode     (div_mode),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // Derived values
  logic [15:0]        spo_eff;
  logic [4:0]         lim;
  logic [16:0]        n_raw;
  logic [NCNT_W-1:0]  n_pick;
  logic [15:0]        dm1;
  logic               x_edge;
  logic [47:0]        x_dividend;
  logic signed [31:0] x_div;
  logic signed [63:0] rnd;
  logic signed [31:0] t;
  logic signed [32:0] contrib;
  logic signed [47:0] base;
  logic signed [48:0] sum_w;
  logic signed [47:0] sum_sat;
  logic signed [36:0] num_f;
  logic [35:0]        num_abs;
  logic [35:0]        q36;
  logic [31:0]        pmag;
  logic signed [31:0] pnew;
  logic               last_term;
  logic               last_idx;
  logic               take_out;
  logic               load_out;

  always_comb begin
    spo_eff = (spo == 16'd0) ? 16'd1 : spo;
    if (mtl == 5'd0) begin
      lim = 5'd1;
    end else if (mtl > 5'(MAX_TERMS)) begin
      lim = 5'(MAX_TERMS);
    end else begin
      lim = mtl;
    end

    // Term count from range length
    if (len_q <= 16'd1)       n_raw = 17'd1;
    else if (len_q <= 16'd3)  n_raw = 17'd2;
    else if (len_q <= 16'd6)  n_raw = 17'd3;
    else if (len_q <= 16'd20) n_raw = 17'd4;
    else                      n_raw = 17'd5 + {1'b0, quotient[15:0]};
    n_pick = (n_raw < {12'b0, lim}) ? NCNT_W'(n_raw) : NCNT_W'(lim);

    // Position to x
    dm1        = len_q - 16'd1;
    x_edge     = (len_q < 16'd2) || (pos >= dm1);
    x_dividend = {1'b0, pos, 31'b0} + {32'b0, 1'b0, dm1[15:1]};
    x_div      = (quotient > 48'h8000_0000) ? ONE_Q30
                                            : 32'(quotient - 48'h4000_0000);

    // Round half up, shift by 30
    rnd     = prod + 64'sh2000_0000;
    t       = rnd[61:30];
    contrib = rnd[62:30];

    // Saturating accumulate
    base  = (pos == 16'd0) ? 48'sd0 : rdata;
    sum_w = {base[47], base} + {{16{contrib[32]}}, contrib};
    if (sum_w[48] != sum_w[47]) begin
      sum_sat = sum_w[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      sum_sat = sum_w[47:0];
    end

    // Recurrence numerator and rounded quotient
    num_f   = num - prod[36:0];
    num_abs = num_f[36] ? 36'(-num_f) : num_f[35:0];
    q36     = quotient[35:0];
    pmag    = (q36 > 36'h4000_0000) ? 32'h4000_0000 : q36[31:0];
    pnew    = neg ? -$signed(pmag) : $signed(pmag);

    last_term = ({1'b0, p} + NCNT_W'(1)) == n_terms;
    last_idx  = ({1'b0, idx} + NCNT_W'(1)) == n_terms;
    take_out  = !coeff_valid || !coeff_stall;
    load_out  = (state == S_E_WR) && take_out;
    rd_addr   = (state == S_E_RD || state == S_E_WR) ? idx : p;
  end

  // Sequencer: next state and unit controls
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_mode     = DIV_Q48;
    div_dividend = '0;
    div_divisor  = '0;
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          state_next = (pos == 16'd0) ? S_PICK_ST : S_X_ST;
        end
      end
      S_PICK_ST: begin
        div_start    = 1'b1;
        div_mode     = DIV_Q16;
        div_dividend = {32'b0, len_q};
        div_divisor  = spo_eff;
        state_next   = S_PICK_WT;
      end
      S_PICK_WT: begin
        if (div_done) state_next = S_X_ST;
      end
      S_X_ST: begin
        if (x_edge) begin
          state_next = S_MS;
        end else begin
          div_start    = 1'b1;
          div_mode     = DIV_Q48;
          div_dividend = x_dividend;
          div_divisor  = dm1;
          state_next   = S_X_WT;
        end
      end
      S_X_WT: begin
        if (div_done) state_next = S_MS;
      end
      S_MS: begin
        mul_en     = 1'b1;
        mul_a      = smp;
        mul_b      = pcur;
        state_next = S_ACC;
      end
      S_ACC: begin
        if (last_term) begin
          state_next = last_q ? S_E_RD : S_IDLE;
        end else begin
          state_next = (p == '0) ? S_MS : S_R1;
        end
      end
      S_R1: begin
        mul_en     = 1'b1;
        mul_a      = x;
        mul_b      = pcur;
        state_next = S_R2;
      end
      S_R2: begin
        mul_en     = 1'b1;
        mul_a      = $signed(32'({p, 1'b0}) - 32'd1);
        mul_b      = t;
        state_next = S_R3;
      end
      S_R3: begin
        mul_en     = 1'b1;
        mul_a      = $signed(32'(p) - 32'd1);
        mul_b      = pprev;
        state_next = S_R4;
      end
      S_R4: begin
        div_start    = 1'b1;
        div_mode     = DIV_Q36;
        div_dividend = {12'b0, num_abs + 36'(p >> 1)};
        div_divisor  = 16'(p);
        state_next   = S_R5;
      end
      S_R5: begin
        if (div_done) state_next = S_MS;
      end
      S_E_RD: begin
        state_next = S_E_WR;
      end
      S_E_WR: begin
        if (take_out) state_next = last_idx ? S_IDLE : S_E_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sum memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_ACC) begin
      sums[p] <= sum_sat;
    end
    rdata <= sums[rd_addr];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spo         <= SPO_RESET;
      mtl         <= MT_RESET;
      pos         <= '0;
      n_terms     <= '0;
      coeff_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SAMPLES_PER_ORDER: spo <= cfg_data;
          REG_MAX_TERMS:         mtl <= cfg_data[4:0];
          default:               ;
        endcase
      end

      // Output register: load a new beat or drop an accepted one
      if (load_out) begin
        coeff_valid <= 1'b1;
      end else if (!coeff_stall) begin
        coeff_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            smp    <= sample.sample_value;
            len_q  <= sample.range_length;
            last_q <= sample.range_last;
          end
        end
        S_PICK_WT: begin
          if (div_done) n_terms <= n_pick;
        end
        S_X_ST: begin
          if (x_edge) x <= ONE_Q30;
          p    <= '0;
          pcur <= ONE_Q30;
        end
        S_X_WT: begin
          if (div_done) x <= x_div;
        end
        S_ACC: begin
          if (!last_term) begin
            p <= p + TERM_W'(1);
            if (p == '0) begin
              pprev <= pcur;
              pcur  <= x;
            end
          end else if (last_q) begin
            pos <= '0;
            idx <= '0;
          end else if (pos != 16'hFFFF) begin
            pos <= pos + 16'd1;
          end
        end
        S_R3: begin
          num <= prod[36:0];
        end
        S_R4: begin
          neg <= num_f[36];
        end
        S_R5: begin
          if (div_done) begin
            pprev <= pcur;
            pcur  <= pnew;
          end
        end
        S_E_WR: begin
          if (take_out) begin
            coeff.coeff_value <= rdata;
            coeff.coeff_index <= 4'(idx);
            coeff.coeff_last  <= last_idx;
            idx               <= idx + TERM_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign sample_stall = (state != S_IDLE);

endmodule

// File: rtl/clp_mul.sv
module clp_mul
  import clp_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  // Registered signed product, loaded when en is high
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// File: rtl/clp_div.sv
module clp_div
  import clp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  div_mode_t   mode,
  input  logic [47:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [47:0] quotient
);

  logic [47:0] dq;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic [4:0]  cnt;

  logic [47:0] dq_w;
  logic [15:0] rem_w;
  logic [16:0] trial;
  logic        qbit;

  // Two restoring steps per cycle
  always_comb begin
    dq_w  = dq;
    rem_w = rem;
    trial = '0;
    qbit  = 1'b0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_w, dq_w[47]};
      if (trial >= {1'b0, dsr}) begin
        rem_w = 16'(trial - {1'b0, dsr});
        qbit  = 1'b1;
      end else begin
        rem_w = trial[15:0];
        qbit  = 1'b0;
      end
      dq_w = {dq_w[46:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        dsr  <= divisor;
        case (mode)
          DIV_Q16: begin
            dq  <= {dividend[15:0], 32'b0};
            cnt <= 5'd8;
          end
          DIV_Q36: begin
            dq  <= {dividend[35:0], 12'b0};
            cnt <= 5'd18;
          end
          default: begin
            dq  <= dividend;
            cnt <= 5'd24;
          end
        endcase
      end else if (busy) begin
        dq  <= dq_w;
        rem <= rem_w;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend bits have all shifted out; dq holds the quotient
  assign quotient = dq;

endmodule
